// ===== hdl/serpent_pkg.sv =====
// ----------------------------------------------------------------------------
// serpent_pkg
// Types, S-box tables and round functions for the Serpent cipher core.
// ----------------------------------------------------------------------------
package serpent_pkg;

  // Four 32-bit words, word k at index k
  typedef logic [3:0][31:0] blk_t;

  typedef enum logic [1:0] {
    KX_LOAD,
    KX_RUN,
    KX_DONE
  } kx_state_t;

  localparam int          NUM_ROUNDS   = 32;
  localparam int          NUM_RKEYS    = 33;
  localparam logic [7:0]  PREKEY_LAST  = 8'd131;
  localparam logic [31:0] GOLDEN       = 32'h9e3779b9;
  localparam int          PREKEY_ROT   = 11;

  localparam logic [3:0] SBOX_TABLE [8][16] = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Inverse S-box entry by search of the forward row
  function automatic logic [3:0] sbox_inv_lut(logic [2:0] box, logic [3:0] nib);
    logic [3:0] res;
    res = '0;
    for (int v = 0; v < 16; v++) begin
      if (SBOX_TABLE[box][v] == nib) res = 4'(v);
    end
    return res;
  endfunction

  // Bitsliced S-box: bit j of word k is bit k of nibble j
  function automatic blk_t sbox_apply(logic [2:0] box, logic inv, blk_t x);
    blk_t       y;
    logic [3:0] n;
    for (int j = 0; j < 32; j++) begin
      n = {x[3][j], x[2][j], x[1][j], x[0][j]};
      n = inv ? sbox_inv_lut(box, n) : SBOX_TABLE[box][n];
      for (int k = 0; k < 4; k++) y[k][j] = n[k];
    end
    return y;
  endfunction

  function automatic blk_t lin_fwd(blk_t xi);
    blk_t x;
    x    = xi;
    x[0] = rotl(x[0], 13);
    x[2] = rotl(x[2], 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = rotl(x[1], 1);
    x[3] = rotl(x[3], 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = rotl(x[0], 5);
    x[2] = rotl(x[2], 22);
    return x;
  endfunction

  function automatic blk_t lin_inv(blk_t xi);
    blk_t x;
    x    = xi;
    x[2] = rotr(x[2], 22);
    x[0] = rotr(x[0], 5);
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[3] = rotr(x[3], 7);
    x[1] = rotr(x[1], 1);
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[2] = rotr(x[2], 3);
    x[0] = rotr(x[0], 13);
    return x;
  endfunction

endpackage

// ===== hdl/serpent_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// serpent_block_cipher_core
// Serpent-256 encrypt/decrypt with one register stage per round.
// ----------------------------------------------------------------------------
// Usage:
//   Write the 256-bit key through the APB port as four 64-bit registers at
//   byte addresses 0, 8, 16, 24 (even word in bits 31:0, odd in 63:32).
//   Each write restarts key expansion (one load, then one prekey word per
//   cycle), during which blk_ready stays low. The same expansion runs after
//   reset with an all-zero key.
//   Input transaction: blk_valid/blk_ready with cmd (0 encrypt, 1 decrypt),
//   block_low and block_high. Output transaction: res_valid/res_ready with
//   result_low and result_high.
//   The pipeline has 32 round stages, the last of which is the output
//   register. One block per cycle is sustained while res_ready is high.
//   When the receiver stalls, each stage holds only if the stage after it is
//   full and held, so bubbles close up and input is still taken until the
//   pipeline is full. Reset empties the pipeline and clears the key.
// ----------------------------------------------------------------------------
module serpent_block_cipher_core (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  // block input
  input  logic                blk_valid,
  output logic                blk_ready,
  input  logic                cmd,
  input  logic [63:0]         block_low,
  input  logic [63:0]         block_high,
  // block output
  output logic                res_valid,
  input  logic                res_ready,
  output logic [63:0]         result_low,
  output logic [63:0]         result_high
);
  import serpent_pkg::*;

  logic [63:0]  key_regs [4];
  logic         cfg_wr;
  kx_state_t    kx_state, kx_state_next;
  logic [7:0]   kx_cnt;
  logic [31:0]  kx_win [8];
  logic [31:0]  kx_word;
  logic [2:0]   kx_box;
  blk_t         rkeys [NUM_RKEYS];

  blk_t         p_data [NUM_ROUNDS];
  logic [NUM_ROUNDS-1:0] p_cmd;
  logic [NUM_ROUNDS-1:0] p_vld;
  logic [NUM_ROUNDS:0]   load;
  logic         in_take;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = key_regs[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_regs[i] <= '0;
    end else if (cfg_wr) begin
      key_regs[paddr[4:3]] <= pwdata;
    end
  end

  // Key expansion sequencer
  always_ff @(posedge clk) begin
    if (rst) kx_state <= KX_LOAD;
    else     kx_state <= kx_state_next;
  end

  always_comb begin
    kx_state_next = kx_state;
    case (kx_state)
      KX_LOAD: kx_state_next = KX_RUN;
      KX_RUN:  if (kx_cnt == PREKEY_LAST) kx_state_next = KX_DONE;
      KX_DONE: kx_state_next = KX_DONE;
      default: kx_state_next = KX_LOAD;
    endcase
    if (cfg_wr) kx_state_next = KX_LOAD;
  end

  // Next prekey word from the sliding window of the last eight
  assign kx_word = rotl(kx_win[0] ^ kx_win[3] ^ kx_win[5] ^ kx_win[7] ^ GOLDEN
                        ^ {24'd0, kx_cnt}, PREKEY_ROT);
  assign kx_box  = 3'd3 - kx_cnt[4:2];

  always_ff @(posedge clk) begin
    if (kx_state == KX_LOAD) begin
      kx_cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        kx_win[2*i]   <= key_regs[i][31:0];
        kx_win[2*i+1] <= key_regs[i][63:32];
      end
    end else if (kx_state == KX_RUN) begin
      kx_cnt <= kx_cnt + 8'd1;
      for (int i = 0; i < 7; i++) kx_win[i] <= kx_win[i+1];
      kx_win[7] <= kx_word;
      // store a round key once its fourth word is out
      if (kx_cnt[1:0] == 2'b11) begin
        rkeys[kx_cnt[7:2]] <= sbox_apply(kx_box, 1'b0,
                                         {kx_word, kx_win[7], kx_win[6], kx_win[5]});
      end
    end
  end

  // Stage advance: a stage loads when empty or when its contents move on
  always_comb begin
    load[NUM_ROUNDS] = res_ready;
    for (int s = NUM_ROUNDS - 1; s >= 0; s--) load[s] = ~p_vld[s] | load[s+1];
  end

  assign blk_ready = load[0] & (kx_state == KX_DONE);
  assign in_take   = blk_valid & blk_ready;

  // Round stages
  for (genvar s = 0; s < NUM_ROUNDS; s++) begin : g_round
    localparam logic [2:0] EBOX = 3'(s % 8);
    localparam logic [2:0] DBOX = 3'((31 - s) % 8);
    localparam int         DR   = 31 - s;

    blk_t x_in, e_val, d_pre, d_val, st_next;
    logic c_in, v_in;

    if (s == 0) begin : g_first
      assign x_in  = {block_high, block_low};
      assign c_in  = cmd;
      assign v_in  = in_take;
      assign d_pre = x_in ^ rkeys[NUM_RKEYS-1];
    end else begin : g_mid
      assign x_in  = p_data[s-1];
      assign c_in  = p_cmd[s-1];
      assign v_in  = p_vld[s-1];
      assign d_pre = lin_inv(x_in);
    end

    if (s == NUM_ROUNDS - 1) begin : g_elast
      assign e_val = sbox_apply(EBOX, 1'b0, x_in ^ rkeys[s]) ^ rkeys[NUM_RKEYS-1];
    end else begin : g_emid
      assign e_val = lin_fwd(sbox_apply(EBOX, 1'b0, x_in ^ rkeys[s]));
    end

    assign d_val   = sbox_apply(DBOX, 1'b1, d_pre) ^ rkeys[DR];
    assign st_next = c_in ? d_val : e_val;

    // hold valid with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        p_vld[s] <= 1'b0;
      end else if (load[s]) begin
        p_vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (load[s]) begin
        p_data[s] <= st_next;
        p_cmd[s]  <= c_in;
      end
    end
  end

  assign res_valid   = p_vld[NUM_ROUNDS-1];
  assign result_low  = {p_data[NUM_ROUNDS-1][1], p_data[NUM_ROUNDS-1][0]};
  assign result_high = {p_data[NUM_ROUNDS-1][3], p_data[NUM_ROUNDS-1][2]};

  // Assertions
  a_no_take_during_kx: assert property (@(posedge clk) disable iff (rst)
    blk_ready |-> kx_state == KX_DONE)
    else $error("block taken while round keys are being expanded");

  a_write_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !blk_ready)
    else $error("input open right after a key write");

  a_kx_count_range: assert property (@(posedge clk) disable iff (rst)
    kx_state == KX_RUN |-> kx_cnt <= PREKEY_LAST)
    else $error("prekey counter ran past its last word");

endmodule
